/* design/fba_pkg.sv */
// ----------------------------------------------------------------------------
// fba_pkg: shared types and codes of the frame bitmap allocator
// Operation and status codes, and the request and response of the divider.
// ----------------------------------------------------------------------------
`default_nettype none

package fba_pkg;

   localparam int unsigned DIV_BITS = 32;

   typedef logic [1:0]  op_type;
   typedef logic [1:0]  status_type;
   typedef logic [31:0] word_type;

   localparam op_type OP_ALLOCATE = 2'd0;
   localparam op_type OP_FREE     = 2'd1;
   localparam op_type OP_RESERVE  = 2'd2;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_NOMEM = 2'd1;
   localparam status_type ST_RANGE = 2'd2;

   localparam logic [7:0] BYTE_FULL  = 8'hFF;
   localparam logic [7:0] BYTE_EMPTY = 8'h00;

   typedef struct packed {
      logic                start;
      logic [DIV_BITS-1:0] dividend;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [DIV_BITS-1:0] quotient;
      logic                rem_nz;
   } div_rsp_type;

endpackage

`default_nettype wire

/* design/fba_ram.sv */
// ----------------------------------------------------------------------------
// fba_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fba_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4096,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/fba_div.sv */
// ----------------------------------------------------------------------------
// fba_div: divider by a constant
// Reciprocal multiplication in two stages: the quotient is registered in the
// cycle after start, the nonzero-remainder flag and done in the cycle after that.
// ----------------------------------------------------------------------------
`default_nettype none

module fba_div #(
   parameter int unsigned DIVISOR = 4096
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire fba_pkg::div_req_type div_req,
   output      fba_pkg::div_rsp_type div_rsp
);

   import fba_pkg::*;

   localparam int unsigned SHIFT  = $clog2(DIVISOR);
   localparam int unsigned MUL_W  = DIV_BITS + 1;
   localparam int unsigned PROD_W = DIV_BITS + MUL_W;
   localparam int unsigned DVS_W  = SHIFT + 1;
   localparam int unsigned BW     = DIV_BITS + DVS_W;
   // ceil(2^(DIV_BITS+SHIFT) / DIVISOR): exact quotient for every dividend
   localparam logic [MUL_W-1:0] RECIP = MUL_W'(((64'd1 << (DIV_BITS + SHIFT))
                                         + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
   localparam logic [DVS_W-1:0] DIVISOR_C = DVS_W'(DIVISOR);

   logic                step_ff, step_in;     // fresh quotient in stage one
   logic                done_ff, done_in;
   logic [DIV_BITS-1:0] dvd_ff, dvd_in;
   logic [DIV_BITS-1:0] quot_ff, quot_in;
   logic                rem_nz_ff, rem_nz_in;
   logic [PROD_W-1:0]   prod;
   logic [BW-1:0]       back;                 // quotient times divisor

   always_comb begin
      prod      = PROD_W'(div_req.dividend) * PROD_W'(RECIP);
      back      = BW'(quot_ff) * BW'(DIVISOR_C);
      step_in   = div_req.start;
      done_in   = step_ff;
      dvd_in    = dvd_ff;
      quot_in   = quot_ff;
      rem_nz_in = rem_nz_ff;
      if (div_req.start) begin
         dvd_in  = div_req.dividend;
         quot_in = DIV_BITS'(prod >> (DIV_BITS + SHIFT));
      end
      if (step_ff) begin
         // remainder is nonzero exactly when the product falls short
         rem_nz_in = (BW'(dvd_ff) != back);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff    <= dvd_in;
      quot_ff   <= quot_in;
      rem_nz_ff <= rem_nz_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;
   assign div_rsp.rem_nz   = rem_nz_ff;

   ap_step_after_start: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> step_ff)
      else $error("divider did not take a start");

   ap_done_after_step: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(step_ff))
      else $error("divider done without a running division");

   ap_quotient_exact: assert property (@(posedge clock) disable iff (reset)
      step_ff |-> ((back <= BW'(dvd_ff)) && ((BW'(dvd_ff) - back) < BW'(DIVISOR_C))))
      else $error("divider quotient off by one or more");

endmodule

`default_nettype wire

/* design/frame_bitmap_allocator_core.sv */
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_core: physical frame allocator on a used-bit map
// Keeps one used bit per frame in a byte-wide RAM and serves allocate, free
// and reserve requests, one at a time, with one response per request.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel carries operation, address and length_bytes; a transfer
//    happens when req_valid is high and req_stall is low. req_stall is high
//    while a request is in progress, so one request runs at a time.
//  - rsp_ channel returns frame_address and status through an output
//    register; a finished request waits there while the next one runs.
//    If the receiver stalls, the following request completes its work and
//    then holds until the output register is free.
//  - Allocate scans map bytes upward from the lowest byte that may hold a
//    free frame (full bytes below it are skipped); free clears one bit;
//    reserve sets bits in each map byte it touches; zero-length reserve,
//    unused code and allocate on a map known to be full go straight to the
//    response. The block passes through idle before the next transfer.
//  - The two-stage reciprocal divider by FRAME_BYTES and the single map RAM
//    with its registered read serve these steps.
//  - Reset: a clearing pass writes zero to all MAP_BYTES map bytes, one a
//    cycle, with req_stall high; requests are taken afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_bitmap_allocator_core #(
   parameter int unsigned MAP_BYTES   = 4096,
   parameter int unsigned FRAME_BYTES = 4096
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire fba_pkg::op_type     req_operation,
   input  wire fba_pkg::word_type   req_address,
   input  wire fba_pkg::word_type   req_length_bytes,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      fba_pkg::word_type   rsp_frame_address,
   output      fba_pkg::status_type rsp_status
);

   import fba_pkg::*;

   // byte index, frame index and hint widths
   localparam int unsigned AW     = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
   localparam int unsigned FW     = AW + 3;
   localparam int unsigned HW     = $clog2(MAP_BYTES + 1);
   localparam int unsigned PROD_W = FW + $clog2(FRAME_BYTES + 1);
   localparam logic [63:0] TOTAL_FRAMES = 64'(MAP_BYTES) * 64'd8;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_ARD, S_ACHK, S_FDIV, S_FRD, S_FWR,
      S_RDIVA, S_RDIVL, S_RRD, S_RWR, S_DONE
   } state_type;

   // control registers
   state_type   state_ff, state_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [HW-1:0] hint_ff, hint_in;      // all bytes below this are full
   logic        rsp_valid_ff, rsp_valid_in;
   div_req_type div_req_ff, div_req_in;

   // payload registers
   word_type    len_ff, len_in;
   word_type    rq_ff, rq_in;            // reserve start frame
   logic [AW-1:0] byte_ff, byte_in;      // current map byte
   logic [2:0]  bitsel_ff, bitsel_in;
   logic [FW-1:0] first_ff, first_in;
   logic [FW-1:0] last_ff, last_in;
   logic [FW-1:0] fidx_ff, fidx_in;
   status_type  st_ff, st_in;
   logic        alloc_ok_ff, alloc_ok_in;
   word_type    rsp_frame_address_ff, rsp_frame_address_in;
   status_type  rsp_status_ff, rsp_status_in;

   // RAM port
   logic          ram_wr_en, ram_rd_en;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   logic [7:0]    ram_wr_data, ram_rd_data;

   div_rsp_type div_rsp;

   // helpers
   logic [2:0]        zero_bit;
   logic [63:0]       count64, end64, end_c64, start64;
   status_type        res_st;
   logic [2:0]        lo_bit, hi_bit;
   logic [7:0]        res_mask;
   logic [PROD_W-1:0] frame_prod;

   fba_ram #(
      .WIDTH (8),
      .DEPTH (MAP_BYTES)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   fba_div #(
      .DIVISOR (FRAME_BYTES)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req_ff),
      .div_rsp (div_rsp)
   );

   // lowest zero bit of the byte just read
   always_comb begin
      zero_bit = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (!ram_rd_data[i]) begin
            zero_bit = 3'(i);
         end
      end
   end

   // reserve range: end frame clipped to the map
   always_comb begin
      start64 = 64'(rq_ff);
      count64 = 64'(div_rsp.quotient) + 64'(div_rsp.rem_nz);
      end64   = start64 + count64;
      if (end64 > TOTAL_FRAMES) begin
         end_c64 = TOTAL_FRAMES;
         res_st  = ST_RANGE;
      end else begin
         end_c64 = end64;
         res_st  = ST_OK;
      end
   end

   // bits of the current byte that fall inside the reserve range
   always_comb begin
      lo_bit   = (byte_ff == first_ff[FW-1:3]) ? first_ff[2:0] : 3'd0;
      hi_bit   = (byte_ff == last_ff[FW-1:3])  ? last_ff[2:0]  : 3'd7;
      res_mask = (BYTE_FULL << lo_bit) & (BYTE_FULL >> (3'd7 - hi_bit));
   end

   assign frame_prod = PROD_W'(fidx_ff) * PROD_W'(FRAME_BYTES);

   always_comb begin
      state_in             = state_ff;
      clr_addr_in          = clr_addr_ff;
      hint_in              = hint_ff;
      rsp_valid_in         = rsp_valid_ff && rsp_stall;   // drop once taken
      div_req_in.start     = 1'b0;
      div_req_in.dividend  = div_req_ff.dividend;
      len_in               = len_ff;
      rq_in                = rq_ff;
      byte_in              = byte_ff;
      bitsel_in            = bitsel_ff;
      first_in             = first_ff;
      last_in              = last_ff;
      fidx_in              = fidx_ff;
      st_in                = st_ff;
      alloc_ok_in          = alloc_ok_ff;
      rsp_frame_address_in = rsp_frame_address_ff;
      rsp_status_in        = rsp_status_ff;
      ram_wr_en            = 1'b0;
      ram_wr_addr          = byte_ff;
      ram_wr_data          = BYTE_EMPTY;
      ram_rd_en            = 1'b0;
      ram_rd_addr          = byte_ff;

      case (state_ff)
         S_CLEAR: begin
            // sweep the map to all free
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = BYTE_EMPTY;
            clr_addr_in = AW'(clr_addr_ff + 1'b1);
            if (clr_addr_ff == AW'(MAP_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               len_in      = req_length_bytes;
               st_in       = ST_OK;
               alloc_ok_in = 1'b0;
               case (req_operation)
                  OP_ALLOCATE: begin
                     if (hint_ff == HW'(MAP_BYTES)) begin
                        st_in    = ST_NOMEM;
                        state_in = S_DONE;
                     end else begin
                        byte_in  = AW'(hint_ff);
                        state_in = S_ARD;
                     end
                  end
                  OP_FREE: begin
                     div_req_in.start    = 1'b1;
                     div_req_in.dividend = req_address;
                     state_in            = S_FDIV;
                  end
                  OP_RESERVE: begin
                     if (req_length_bytes == '0) begin
                        state_in = S_DONE;
                     end else begin
                        div_req_in.start    = 1'b1;
                        div_req_in.dividend = req_address;
                        state_in            = S_RDIVA;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_ARD: begin
            ram_rd_en = 1'b1;
            state_in  = S_ACHK;
         end
         S_ACHK: begin
            if (ram_rd_data != BYTE_FULL) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = ram_rd_data | (8'd1 << zero_bit);
               fidx_in     = {byte_ff, zero_bit};
               alloc_ok_in = 1'b1;
               hint_in     = HW'(byte_ff);
               state_in    = S_DONE;
            end else if (byte_ff == AW'(MAP_BYTES - 1)) begin
               st_in    = ST_NOMEM;
               hint_in  = HW'(MAP_BYTES);
               state_in = S_DONE;
            end else begin
               byte_in  = AW'(byte_ff + 1'b1);
               state_in = S_ARD;
            end
         end
         S_FDIV: begin
            if (div_rsp.done) begin
               if (64'(div_rsp.quotient) >= TOTAL_FRAMES) begin
                  st_in    = ST_RANGE;
                  state_in = S_DONE;
               end else begin
                  byte_in   = AW'(div_rsp.quotient >> 3);
                  bitsel_in = div_rsp.quotient[2:0];
                  state_in  = S_FRD;
               end
            end
         end
         S_FRD: begin
            ram_rd_en = 1'b1;
            state_in  = S_FWR;
         end
         S_FWR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = ram_rd_data & ~(8'd1 << bitsel_ff);
            if (HW'(byte_ff) < hint_ff) begin
               hint_in = HW'(byte_ff);
            end
            state_in = S_DONE;
         end
         S_RDIVA: begin
            if (div_rsp.done) begin
               rq_in               = div_rsp.quotient;
               div_req_in.start    = 1'b1;
               div_req_in.dividend = len_ff;
               state_in            = S_RDIVL;
            end
         end
         S_RDIVL: begin
            if (div_rsp.done) begin
               st_in = res_st;
               if (start64 >= end_c64) begin
                  state_in = S_DONE;
               end else begin
                  first_in = FW'(rq_ff);
                  last_in  = FW'(end_c64 - 64'd1);
                  byte_in  = AW'(rq_ff >> 3);
                  state_in = S_RRD;
               end
            end
         end
         S_RRD: begin
            ram_rd_en = 1'b1;
            state_in  = S_RWR;
         end
         S_RWR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = ram_rd_data | res_mask;
            if (byte_ff == last_ff[FW-1:3]) begin
               state_in = S_DONE;
            end else begin
               byte_in  = AW'(byte_ff + 1'b1);
               state_in = S_RRD;
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in         = 1'b1;
               rsp_status_in        = st_ff;
               rsp_frame_address_in = alloc_ok_ff ? 32'(frame_prod) : '0;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_CLEAR;
         clr_addr_ff      <= '0;
         hint_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
         div_req_ff.start <= 1'b0;
      end else begin
         state_ff         <= state_in;
         clr_addr_ff      <= clr_addr_in;
         hint_ff          <= hint_in;
         rsp_valid_ff     <= rsp_valid_in;
         div_req_ff.start <= div_req_in.start;
      end
   end

   always_ff @(posedge clock) begin
      div_req_ff.dividend  <= div_req_in.dividend;
      len_ff               <= len_in;
      rq_ff                <= rq_in;
      byte_ff              <= byte_in;
      bitsel_ff            <= bitsel_in;
      first_ff             <= first_in;
      last_ff              <= last_in;
      fidx_ff              <= fidx_in;
      st_ff                <= st_in;
      alloc_ok_ff          <= alloc_ok_in;
      rsp_frame_address_ff <= rsp_frame_address_in;
      rsp_status_ff        <= rsp_status_in;
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_address = rsp_frame_address_ff;
   assign rsp_status        = rsp_status_ff;

   ap_ram_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("map read and write in the same cycle");

   ap_hint_bound: assert property (@(posedge clock) disable iff (reset)
      hint_ff <= HW'(MAP_BYTES))
      else $error("free-byte hint past the end of the map");

   ap_addr_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != ST_OK) |-> (rsp_frame_address_ff == '0))
      else $error("nonzero frame address with an error status");

   ap_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("response raised outside the completion state");

endmodule

`default_nettype wire
